// File: rtl/smvm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvm_pkg
// Shared types and constants of the sphere-masked voxel matrix-vector block.
// ----------------------------------------------------------------------------
package smvm_pkg;

  // Default sizes of the stores and the saturation width.
  localparam int GRID_DIM_DEF    = 64;
  localparam int WEIGHT_ROWS_DEF = 4096;
  localparam int LATENT_MAX_DEF  = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  // Fixed field widths.
  localparam int COORD_W   = 6;
  localparam int ROW_NUM_W = 12;
  localparam int POS_W     = 4;
  localparam int VAL_W     = 32;
  localparam int FRAC_BITS = 16;

  // Input stream packing, lowest bit first.
  localparam int CZ_LSB      = 0;
  localparam int CY_LSB      = 6;
  localparam int CX_LSB      = 12;
  localparam int ROW_LSB     = 18;
  localparam int POS_LSB     = 30;
  localparam int PART_LSB    = 34;
  localparam int WVAL_LSB    = 35;
  localparam int PREV_RE_LSB = 67;
  localparam int PREV_IM_LSB = 99;
  localparam int IN_DATA_W   = 136;
  localparam int IN_USER_W   = 3;
  localparam int OUT_DATA_W  = 64;
  localparam int OUT_USER_W  = 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOL_DEPTH   = 3'd0,
    CFG_VOL_HEIGHT  = 3'd1,
    CFG_GRID_OFFSET = 3'd2,
    CFG_RADIUS_SQ   = 3'd3,
    CFG_LATENT_LEN  = 3'd4,
    CFG_BIAS_ENABLE = 3'd5
  } cfg_idx_t;

  // Register reset values.
  localparam logic [6:0]  VOL_DEPTH_RST   = 7'd64;
  localparam logic [6:0]  VOL_HEIGHT_RST  = 7'd64;
  localparam logic [4:0]  GRID_OFFSET_RST = 5'd0;
  localparam logic [13:0] RADIUS_SQ_RST   = 14'd12288;
  localparam logic [4:0]  LATENT_LEN_RST  = 5'd16;
  localparam logic        BIAS_ENABLE_RST = 1'b1;

  // Request kinds carried in the input tuser.
  typedef enum logic [2:0] {
    REQ_GRID   = 3'd0,
    REQ_WEIGHT = 3'd1,
    REQ_BIAS   = 3'd2,
    REQ_LATENT = 3'd3,
    REQ_QUERY  = 3'd4
  } req_t;

  // Controls from the sequencer to the complex accumulator.
  typedef struct packed {
    logic load;      // start from the previous values
    logic step;      // weight and latent read data are present
    logic add_bias;  // add the row bias once
  } mac_ctl_t;

endpackage

// File: rtl/smvm_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smvm_mac
// Complex multiply-accumulate: product, round to Q16.16, wide sum, saturate.
// ----------------------------------------------------------------------------
module smvm_mac import smvm_pkg::*; #(
  parameter int LATENT_MAX = LATENT_MAX_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] prev_re,
  input  logic signed [VAL_W-1:0] prev_im,
  input  logic signed [VAL_W-1:0] w_re,
  input  logic signed [VAL_W-1:0] w_im,
  input  logic signed [VAL_W-1:0] lat,
  input  logic signed [VAL_W-1:0] bias_re,
  input  logic signed [VAL_W-1:0] bias_im,
  output logic signed [VAL_W-1:0] res_re,
  output logic signed [VAL_W-1:0] res_im,
  output logic                    busy
);

  localparam int PROD_W = 2 * VAL_W;
  localparam int TERM_W = PROD_W - FRAC_BITS;
  localparam int ACC_W  = TERM_W + $clog2(LATENT_MAX + 1) + 2;
  localparam int SAT_W  = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
  localparam logic signed [ACC_W-1:0]  SAT_HI    = (ACC_W'(1) << (SAT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0]  SAT_LO    = -SAT_HI - ACC_W'(1);
  localparam logic signed [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_re, prod_im;
  logic signed [PROD_W-1:0] rnd_re, rnd_im;
  logic signed [TERM_W-1:0] term_re, term_im;
  logic signed [ACC_W-1:0]  acc_re, acc_im;
  logic                     mul_vld, term_vld;

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld  <= 1'b0;
      term_vld <= 1'b0;
    end else begin
      mul_vld  <= ctl.step;
      term_vld <= mul_vld;
    end
  end

  // Round half up: add half an LSB, then drop the fraction arithmetically.
  assign rnd_re = prod_re + ROUND_ADD;
  assign rnd_im = prod_im + ROUND_ADD;

  // Multiply, round and accumulate stages.
  always_ff @(posedge clk) begin
    prod_re <= w_re * lat;
    prod_im <= w_im * lat;
    term_re <= rnd_re[PROD_W-1:FRAC_BITS];
    term_im <= rnd_im[PROD_W-1:FRAC_BITS];
    if (ctl.load) begin
      acc_re <= ACC_W'(prev_re);
      acc_im <= ACC_W'(prev_im);
    end else if (term_vld) begin
      acc_re <= acc_re + ACC_W'(term_re);
      acc_im <= acc_im + ACC_W'(term_im);
    end else if (ctl.add_bias) begin
      acc_re <= acc_re + ACC_W'(bias_re);
      acc_im <= acc_im + ACC_W'(bias_im);
    end
  end

  // Saturate the exact sums once.
  always_comb begin
    if (acc_re > SAT_HI) begin
      res_re = VAL_W'(SAT_HI);
    end else if (acc_re < SAT_LO) begin
      res_re = VAL_W'(SAT_LO);
    end else begin
      res_re = VAL_W'(acc_re);
    end
    if (acc_im > SAT_HI) begin
      res_im = VAL_W'(SAT_HI);
    end else if (acc_im < SAT_LO) begin
      res_im = VAL_W'(SAT_LO);
    end else begin
      res_im = VAL_W'(acc_im);
    end
  end

  assign busy = mul_vld | term_vld;

endmodule

// File: rtl/sphere_masked_voxel_matvec_top.sv
`timescale 1ns / 1ps
// Store writes (grid, weight, bias, latent) pass through S_PREP, S_ADDR and S_STORE,
// and the next input is taken only back in S_IDLE. A voxel outside the radius goes from
// S_STORE straight to S_DONE for its result; a voxel inside runs a dot product of n terms, where n is
// latent_len clamped to LATENT_MAX: the weight memory port reads one element a cycle.
// Synchronous reset restores the configuration registers and clears control state;
// the stores are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
// sphere_masked_voxel_matvec_top
// Store loader and sphere-masked complex dot product over memory-resident rows.
// ----------------------------------------------------------------------------
module sphere_masked_voxel_matvec_top import smvm_pkg::*; #(
  parameter int GRID_DIM    = GRID_DIM_DEF,
  parameter int WEIGHT_ROWS = WEIGHT_ROWS_DEF,
  parameter int LATENT_MAX  = LATENT_MAX_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // coord_z[5:0], coord_y[11:6], coord_x[17:12], row_number[29:18],
  // latent_pos[33:30], complex_part[34], write_value[66:35],
  // prev_real[98:67], prev_imag[130:99], zero fill[135:131]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[2:0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // real_part[31:0], imag_part[63:32]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // in_sphere[0]
  output logic [OUT_USER_W-1:0] m_tuser,
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Store geometry.
  localparam int GRID_DEPTH = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int GC_W       = $clog2(GRID_DIM);
  localparam int GA_W       = $clog2(GRID_DEPTH);
  localparam int ROW_IW     = $clog2(WEIGHT_ROWS);
  localparam int LAT_IW     = (LATENT_MAX > 1) ? $clog2(LATENT_MAX) : 1;
  localparam int CNT_W      = $clog2(LATENT_MAX + 1);
  localparam int W_DEPTH    = WEIGHT_ROWS * LATENT_MAX;
  localparam int WA_W       = $clog2(W_DEPTH);

  // Reciprocal constants for the wrap of grid coordinates, rows and positions.
  localparam int GSUM_W     = COORD_W + 1;
  localparam int GRID_SH    = 16;
  localparam int GRID_RECIP = ((1 << GRID_SH) + GRID_DIM - 1) / GRID_DIM;
  localparam int GPROD_W    = GSUM_W + GRID_SH + 1;
  localparam int ROW_SH     = 28;
  localparam int ROW_RECIP  = ((1 << ROW_SH) + WEIGHT_ROWS - 1) / WEIGHT_ROWS;
  localparam int RPROD_W    = ROW_NUM_W + ROW_SH + 1;
  localparam int POS_SH     = 12;
  localparam int POS_RECIP  = ((1 << POS_SH) + LATENT_MAX - 1) / LATENT_MAX;
  localparam int PPROD_W    = POS_W + POS_SH + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_PREP  = 10'b0000000010,
    S_ADDR  = 10'b0000000100,
    S_STORE = 10'b0000001000,
    S_ROW   = 10'b0000010000,
    S_ROWR  = 10'b0000100000,
    S_MAC   = 10'b0001000000,
    S_DRAIN = 10'b0010000000,
    S_BIAS  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [6:0]  vol_depth, vol_height;
  logic [4:0]  grid_offset, latent_len;
  logic [13:0] radius_sq_limit;
  logic        bias_enable;

  // Current item.
  req_t                    req;
  logic [COORD_W-1:0]      cz, cy, cx;
  logic [ROW_NUM_W-1:0]    row_in;
  logic [POS_W-1:0]        pos_in;
  logic                    part_in;
  logic signed [VAL_W-1:0] wval;

  // Address arithmetic registers.
  logic [GSUM_W-1:0]    g_z, g_y, g_x, gq_z, gq_y, gq_x;
  logic [GC_W-1:0]      gm_z, gm_y, gm_x;
  logic [ROW_NUM_W-1:0] row_q;
  logic [ROW_IW-1:0]    row_r;
  logic [POS_W-1:0]     pos_q;
  logic [LAT_IW-1:0]    pos_r;
  logic                 in_rad;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 rd_vld;

  // Memories and their registered read data.
  logic [ROW_NUM_W-1:0]    grid_mem [GRID_DEPTH];
  logic signed [VAL_W-1:0] weight_re_mem [W_DEPTH];
  logic signed [VAL_W-1:0] weight_im_mem [W_DEPTH];
  logic signed [VAL_W-1:0] bias_re_mem [WEIGHT_ROWS];
  logic signed [VAL_W-1:0] bias_im_mem [WEIGHT_ROWS];
  logic signed [VAL_W-1:0] lat_mem [LATENT_MAX];
  logic [ROW_NUM_W-1:0]    grid_rd;
  logic signed [VAL_W-1:0] w_re_rd, w_im_rd, bias_re_rd, bias_im_rd, lat_rd;

  // Combinational helpers.
  logic                 s_xfer;
  logic [GSUM_W-1:0]    gs_z, gs_y, gs_x;
  logic [5:0]           ctr_z, ctr_y;
  logic signed [7:0]    zp, yp, xp;
  logic signed [15:0]   sq_z, sq_y, sq_x;
  logic [15:0]          r2;
  logic [ROW_NUM_W-1:0] row_src;
  logic [CNT_W-1:0]     n_eff;
  logic                 issue;
  logic [LAT_IW-1:0]    w_idx;
  logic [GA_W-1:0]      ga;
  logic [WA_W-1:0]      wa;
  logic                 grid_we, grid_re, wre_we, wim_we, bre_we, bim_we, lat_we;
  logic                 bias_rd_en, out_load;

  // Accumulator interface.
  mac_ctl_t                mac_ctl;
  logic signed [VAL_W-1:0] mac_re, mac_im;
  logic                    mac_busy;

  // Output register.
  logic signed [VAL_W-1:0] out_re, out_im;
  logic                    out_in_sphere;

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid & s_tready;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      vol_depth       <= VOL_DEPTH_RST;
      vol_height      <= VOL_HEIGHT_RST;
      grid_offset     <= GRID_OFFSET_RST;
      radius_sq_limit <= RADIUS_SQ_RST;
      latent_len      <= LATENT_LEN_RST;
      bias_enable     <= BIAS_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOL_DEPTH:   vol_depth       <= cfg_data[6:0];
        CFG_VOL_HEIGHT:  vol_height      <= cfg_data[6:0];
        CFG_GRID_OFFSET: grid_offset     <= cfg_data[4:0];
        CFG_RADIUS_SQ:   radius_sq_limit <= cfg_data[13:0];
        CFG_LATENT_LEN:  latent_len      <= cfg_data[4:0];
        CFG_BIAS_ENABLE: bias_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Grid coordinates: queries add the padding in z and y.
  assign gs_z = GSUM_W'(cz) + ((req == REQ_QUERY) ? GSUM_W'(grid_offset) : GSUM_W'(0));
  assign gs_y = GSUM_W'(cy) + ((req == REQ_QUERY) ? GSUM_W'(grid_offset) : GSUM_W'(0));
  assign gs_x = GSUM_W'(cx);

  // Centered coordinates and squared radius; an empty volume centers at zero.
  assign ctr_z = (vol_depth == 7'd0) ? 6'd0 : 6'((vol_depth - 7'd1) >> 1);
  assign ctr_y = (vol_height == 7'd0) ? 6'd0 : 6'((vol_height - 7'd1) >> 1);
  assign zp    = $signed({2'b00, cz}) - $signed({2'b00, ctr_z});
  assign yp    = $signed({2'b00, cy}) - $signed({2'b00, ctr_y});
  assign xp    = $signed({2'b00, cx});
  assign sq_z  = zp * zp;
  assign sq_y  = yp * yp;
  assign sq_x  = xp * xp;
  assign r2    = 16'(sq_z) + 16'(sq_y) + 16'(sq_x);

  // Row source: the item's row for writes, the grid entry for a query.
  assign row_src = (state == S_ROW || state == S_ROWR) ? grid_rd : row_in;

  // Dot product length, clamped to the latent store.
  assign n_eff = (int'(latent_len) > LATENT_MAX) ? CNT_W'(LATENT_MAX) : CNT_W'(latent_len);
  assign issue = (state == S_MAC) && (issue_cnt != n_eff);
  assign w_idx = (state == S_MAC) ? issue_cnt[LAT_IW-1:0] : pos_r;

  // Memory addresses.
  assign ga = GA_W'((32'(gm_z) * GRID_DIM + 32'(gm_y)) * GRID_DIM + 32'(gm_x));
  assign wa = WA_W'(32'(row_r) * LATENT_MAX + 32'(w_idx));

  // Wrap arithmetic: quotient by reciprocal, then remainder.
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      g_z    <= gs_z;
      g_y    <= gs_y;
      g_x    <= gs_x;
      gq_z   <= GSUM_W'((GPROD_W'(gs_z) * GPROD_W'(GRID_RECIP)) >> GRID_SH);
      gq_y   <= GSUM_W'((GPROD_W'(gs_y) * GPROD_W'(GRID_RECIP)) >> GRID_SH);
      gq_x   <= GSUM_W'((GPROD_W'(gs_x) * GPROD_W'(GRID_RECIP)) >> GRID_SH);
      pos_q  <= POS_W'((PPROD_W'(pos_in) * PPROD_W'(POS_RECIP)) >> POS_SH);
      in_rad <= (r2 < 16'(radius_sq_limit));
    end
    if (state == S_PREP || state == S_ROW) begin
      row_q <= ROW_NUM_W'((RPROD_W'(row_src) * RPROD_W'(ROW_RECIP)) >> ROW_SH);
    end
    if (state == S_ADDR) begin
      gm_z  <= GC_W'(32'(g_z) - 32'(gq_z) * GRID_DIM);
      gm_y  <= GC_W'(32'(g_y) - 32'(gq_y) * GRID_DIM);
      gm_x  <= GC_W'(32'(g_x) - 32'(gq_x) * GRID_DIM);
      pos_r <= LAT_IW'(32'(pos_in) - 32'(pos_q) * LATENT_MAX);
    end
    if (state == S_ADDR || state == S_ROWR) begin
      row_r <= ROW_IW'(32'(row_src) - 32'(row_q) * WEIGHT_ROWS);
    end
  end

  // Capture the item on its transfer.
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      req     <= req_t'(s_tuser[2:0]);
      cz      <= s_tdata[CZ_LSB +: COORD_W];
      cy      <= s_tdata[CY_LSB +: COORD_W];
      cx      <= s_tdata[CX_LSB +: COORD_W];
      row_in  <= s_tdata[ROW_LSB +: ROW_NUM_W];
      pos_in  <= s_tdata[POS_LSB +: POS_W];
      part_in <= s_tdata[PART_LSB];
      wval    <= s_tdata[WVAL_LSB +: VAL_W];
    end
  end

  // Sequencer: next state and memory strobes.
  always_comb begin
    state_next = state;
    grid_we    = 1'b0;
    grid_re    = 1'b0;
    wre_we     = 1'b0;
    wim_we     = 1'b0;
    bre_we     = 1'b0;
    bim_we     = 1'b0;
    lat_we     = 1'b0;
    bias_rd_en = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_PREP;
      end
      S_PREP:  state_next = S_ADDR;
      S_ADDR:  state_next = S_STORE;
      S_STORE: begin
        state_next = S_IDLE;
        case (req)
          REQ_GRID:   grid_we = 1'b1;
          REQ_WEIGHT: begin
            wre_we = ~part_in;
            wim_we = part_in;
          end
          REQ_BIAS: begin
            bre_we = ~part_in;
            bim_we = part_in;
          end
          REQ_LATENT: lat_we = 1'b1;
          REQ_QUERY: begin
            if (in_rad) begin
              grid_re    = 1'b1;
              state_next = S_ROW;
            end else begin
              state_next = S_DONE;
            end
          end
          default: ;
        endcase
      end
      S_ROW:  state_next = S_ROWR;
      S_ROWR: state_next = S_MAC;
      S_MAC: begin
        bias_rd_en = 1'b1;
        if (!issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!rd_vld && !mac_busy) state_next = S_BIAS;
      end
      S_BIAS: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      issue_cnt <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (state == S_ROWR) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
    end
  end

  // Grid-to-row map.
  always_ff @(posedge clk) begin
    if (grid_we) grid_mem[ga] <= row_in;
    if (grid_re) grid_rd <= grid_mem[ga];
  end

  // Weight rows, real and imaginary halves read at the same address.
  always_ff @(posedge clk) begin
    if (wre_we) weight_re_mem[wa] <= wval;
    if (issue) w_re_rd <= weight_re_mem[wa];
  end

  always_ff @(posedge clk) begin
    if (wim_we) weight_im_mem[wa] <= wval;
    if (issue) w_im_rd <= weight_im_mem[wa];
  end

  // Row biases.
  always_ff @(posedge clk) begin
    if (bre_we) bias_re_mem[row_r] <= wval;
    if (bias_rd_en) bias_re_rd <= bias_re_mem[row_r];
  end

  always_ff @(posedge clk) begin
    if (bim_we) bias_im_mem[row_r] <= wval;
    if (bias_rd_en) bias_im_rd <= bias_im_mem[row_r];
  end

  // Latent vector.
  always_ff @(posedge clk) begin
    if (lat_we) lat_mem[w_idx] <= wval;
    if (issue) lat_rd <= lat_mem[w_idx];
  end

  // Complex accumulator.
  assign mac_ctl.load     = s_xfer;
  assign mac_ctl.step     = rd_vld;
  assign mac_ctl.add_bias = (state == S_BIAS) && bias_enable;

  smvm_mac #(
    .LATENT_MAX(LATENT_MAX),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .prev_re(s_tdata[PREV_RE_LSB +: VAL_W]),
    .prev_im(s_tdata[PREV_IM_LSB +: VAL_W]),
    .w_re   (w_re_rd),
    .w_im   (w_im_rd),
    .lat    (lat_rd),
    .bias_re(bias_re_rd),
    .bias_im(bias_im_rd),
    .res_re (mac_re),
    .res_im (mac_im),
    .busy   (mac_busy)
  );

  // Output register decouples the result from the next item.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re        <= mac_re;
      out_im        <= mac_im;
      out_in_sphere <= in_rad;
    end
  end

  assign m_tdata = {out_im, out_re};
  assign m_tuser = out_in_sphere;

  // A result only appears out of the final sequencer step.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside the final step");

  // Weight reads are only issued by the dot product loop.
  a_read_in_mac: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state == S_MAC))
    else $error("weight read data without an issued read");

  // The accumulator pipeline is empty whenever a new item may be taken.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!rd_vld && !mac_busy))
    else $error("accumulator busy while accepting a new item");

endmodule

// File: tb/sphere_masked_voxel_matvec_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_masked_voxel_matvec_top_tb
// Self-checking bench for the sphere-masked complex voxel dot product block.
// It loads the latent vector and a pool of complete weight rows, then mixes
// store writes and voxel queries with random gaps and result stalls. A local
// model of the stores and registers predicts every query result, and a
// checker compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module sphere_masked_voxel_matvec_top_tb;
  import smvm_pkg::*;

  localparam int           STALL_LIMIT   = 4000;
  localparam int           SETTLE_CYCLES = 40;
  localparam int           REQ_KIND_LAST = 7;
  localparam int           ROW_ENTRIES   = 2 * LATENT_MAX_DEF + 2;
  localparam int           GRID_ENTRIES  = GRID_DIM_DEF * GRID_DIM_DEF * GRID_DIM_DEF;
  localparam logic [31:0]  VALUE_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0]  VALUE_MIN     = 32'h8000_0000;
  localparam longint       SAT_HI        = (longint'(1) << (DATA_WIDTH_DEF - 1)) - 1;
  localparam longint       SAT_LO        = -SAT_HI - 1;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  z;
    logic [5:0]  y;
    logic [5:0]  x;
    logic [11:0] row;
    logic [3:0]  pos;
    logic        part;
    logic [31:0] wval;
    logic [31:0] prev_re;
    logic [31:0] prev_im;
  } voxel_req_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        in_sphere;
  } voxel_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Handshake and result values sampled in the middle of each cycle.
  logic                  in_xfer_q = 1'b0;
  logic                  out_xfer_q = 1'b0;
  logic [OUT_DATA_W-1:0] out_data_q = '0;
  logic [OUT_USER_W-1:0] out_user_q = '0;

  // Mirror of the configuration registers.
  logic [6:0]  depth_cfg  = VOL_DEPTH_RST;
  logic [6:0]  height_cfg = VOL_HEIGHT_RST;
  logic [4:0]  offset_cfg = GRID_OFFSET_RST;
  logic [13:0] radius_cfg = RADIUS_SQ_RST;
  logic [4:0]  len_cfg    = LATENT_LEN_RST;
  logic        bias_cfg   = BIAS_ENABLE_RST;

  // Mirror of the stores, with fill tracking so no unwritten entry is read.
  bit [11:0]   grid_map     [0:GRID_ENTRIES-1];
  bit          grid_written [0:GRID_ENTRIES-1];
  int          weight_mem   [0:WEIGHT_ROWS_DEF*LATENT_MAX_DEF*2-1];
  int          bias_mem     [0:WEIGHT_ROWS_DEF*2-1];
  int          latent_mem   [0:LATENT_MAX_DEF-1];
  bit [33:0]   row_fill     [0:WEIGHT_ROWS_DEF-1];
  bit          row_pooled   [0:WEIGHT_ROWS_DEF-1];
  logic [11:0] loaded_rows  [$];
  logic [17:0] voxel_history[$];

  voxel_result_t voxel_expect_q[$];
  voxel_result_t oldest_voxel;
  int            error_count = 0;
  int            idle_cycles = 0;
  int            stall_left  = 0;
  int            stall_len   = 0;
  bit            tx_gaps_on  = 1'b1;
  bit            rx_stalls_on = 1'b1;

  sphere_masked_voxel_matvec_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample handshakes at the falling edge so the rising edge sees settled values.
  always @(negedge clk) begin
    in_xfer_q  <= s_tvalid && s_tready;
    out_xfer_q <= m_tvalid && m_tready;
    out_data_q <= m_tdata;
    out_user_q <= m_tuser;
  end

  // Gap length for both sides: mostly none or short, now and then long.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Q16.16 value: mostly modest, sometimes full range, sometimes an extreme.
  function automatic logic [31:0] random_q16();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 32'h7FFFF) - 32'h40000;
    if (r < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return '1;
      default: return '0;
    endcase
  endfunction

  function automatic voxel_req_t random_request(logic [2:0] kind);
    voxel_req_t q;
    q.kind    = kind;
    q.z       = $urandom;
    q.y       = $urandom;
    q.x       = $urandom;
    q.row     = $urandom;
    q.pos     = $urandom;
    q.part    = $urandom;
    q.wval    = random_q16();
    q.prev_re = random_q16();
    q.prev_im = random_q16();
    return q;
  endfunction

  function automatic logic [11:0] pick_loaded_row();
    return loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
  endfunction

  function automatic int volume_center(logic [6:0] size);
    return (size == 0) ? 0 : (int'(size) - 1) / 2;
  endfunction

  // Squared radius of the centered voxel against the limit.
  function automatic bit voxel_inside(logic [5:0] z, logic [5:0] y, logic [5:0] x);
    int zc;
    int yc;
    int xc;
    zc = int'(z) - volume_center(depth_cfg);
    yc = int'(y) - volume_center(height_cfg);
    xc = int'(x);
    return (xc * xc + yc * yc + zc * zc) < int'(radius_cfg);
  endfunction

  // Padded grid address of a voxel; z and y wrap around the grid.
  function automatic logic [17:0] lookup_index(logic [5:0] z, logic [5:0] y, logic [5:0] x);
    logic [5:0] gz;
    logic [5:0] gy;
    gz = z + offset_cfg;
    gy = y + offset_cfg;
    return {gz, gy, x};
  endfunction

  // Q32.32 product rounded half up to Q16.16.
  function automatic longint rounded_product(int w, int l);
    longint p;
    p = longint'(w) * longint'(l) + 64'sd32768;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] saturate(longint v);
    if (v > SAT_HI) return SAT_HI[31:0];
    if (v < SAT_LO) return SAT_LO[31:0];
    return v[31:0];
  endfunction

  // Apply one accepted request to the store mirror; queries yield a prediction.
  task automatic predict_transfer(voxel_req_t q);
    voxel_result_t res;
    longint        acc_re;
    longint        acc_im;
    logic [11:0]   r;
    int            n;
    int            j;
    case (q.kind)
      REQ_GRID: begin
        grid_map[{q.z, q.y, q.x}]     = q.row;
        grid_written[{q.z, q.y, q.x}] = 1'b1;
      end
      REQ_WEIGHT: begin
        weight_mem[{q.row, q.pos, q.part}] = q.wval;
        row_fill[q.row][{q.pos, q.part}]   = 1'b1;
      end
      REQ_BIAS: begin
        bias_mem[{q.row, q.part}]        = q.wval;
        row_fill[q.row][32 + int'(q.part)] = 1'b1;
      end
      REQ_LATENT: begin
        latent_mem[q.pos] = q.wval;
      end
      REQ_QUERY: begin
        acc_re = longint'($signed(q.prev_re));
        acc_im = longint'($signed(q.prev_im));
        res.in_sphere = voxel_inside(q.z, q.y, q.x);
        if (res.in_sphere) begin
          r = grid_map[lookup_index(q.z, q.y, q.x)];
          n = (len_cfg > LATENT_MAX_DEF) ? LATENT_MAX_DEF : int'(len_cfg);
          for (j = 0; j < n; j++) begin
            acc_re += rounded_product(weight_mem[{r, 4'(j), 1'b0}], latent_mem[j]);
            acc_im += rounded_product(weight_mem[{r, 4'(j), 1'b1}], latent_mem[j]);
          end
          if (bias_cfg) begin
            acc_re += bias_mem[{r, 1'b0}];
            acc_im += bias_mem[{r, 1'b1}];
          end
        end
        res.re = saturate(acc_re);
        res.im = saturate(acc_im);
        voxel_expect_q.push_back(res);
      end
      default: begin
      end
    endcase
  endtask

  // One input transfer, after an optional gap; valid stays high on exit.
  task automatic send_request(voxel_req_t q);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    word = '0;
    word[CZ_LSB +: COORD_W]        = q.z;
    word[CY_LSB +: COORD_W]        = q.y;
    word[CX_LSB +: COORD_W]        = q.x;
    word[ROW_LSB +: ROW_NUM_W]     = q.row;
    word[POS_LSB +: POS_W]         = q.pos;
    word[PART_LSB]                 = q.part;
    word[WVAL_LSB +: VAL_W]        = q.wval;
    word[PREV_RE_LSB +: VAL_W]     = q.prev_re;
    word[PREV_IM_LSB +: VAL_W]     = q.prev_im;
    gap = tx_gaps_on ? random_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= q.kind;
    do @(posedge clk); while (in_xfer_q !== 1'b1);
    predict_transfer(q);
  endtask

  // Point the grid entry that a voxel looks up at the given row.
  task automatic map_voxel(logic [5:0] z, logic [5:0] y, logic [5:0] x, logic [11:0] row);
    voxel_req_t q;
    q = random_request(REQ_GRID);
    {q.z, q.y, q.x} = lookup_index(z, y, x);
    q.row = row;
    send_request(q);
  endtask

  // A query; an inside voxel whose lookup is not backed by a full row gets mapped first.
  task automatic send_query(logic [5:0] z, logic [5:0] y, logic [5:0] x,
                            logic [31:0] pre, logic [31:0] pim);
    voxel_req_t  q;
    logic [17:0] spot;
    spot = lookup_index(z, y, x);
    if (voxel_inside(z, y, x) && !(grid_written[spot] && (&row_fill[grid_map[spot]])))
      map_voxel(z, y, x, pick_loaded_row());
    q = random_request(REQ_QUERY);
    q.z       = z;
    q.y       = y;
    q.x       = x;
    q.prev_re = pre;
    q.prev_im = pim;
    send_request(q);
    voxel_history.push_back({z, y, x});
    if (voxel_history.size() > 32) void'(voxel_history.pop_front());
  endtask

  // Write every weight element and both biases of a row, then add it to the pool.
  task automatic load_row(logic [11:0] row);
    voxel_req_t q;
    int         k;
    for (k = 0; k < ROW_ENTRIES; k++) begin
      q = random_request((k < 2 * LATENT_MAX_DEF) ? REQ_WEIGHT : REQ_BIAS);
      q.row  = row;
      q.pos  = 4'(k >> 1);
      q.part = k[0];
      send_request(q);
    end
    if (!row_pooled[row]) begin
      row_pooled[row] = 1'b1;
      loaded_rows.push_back(row);
    end
  endtask

  // Drop valid, drain all predictions, then let the last write settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (voxel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all six registers back to back while the block is idle.
  task automatic apply_settings(logic [6:0] depth, logic [6:0] height, logic [4:0] offset,
                                logic [13:0] radius, logic [4:0] len, logic bias);
    wait_idle();
    cfg_write(CFG_VOL_DEPTH, CFG_DATA_W'(depth));
    cfg_write(CFG_VOL_HEIGHT, CFG_DATA_W'(height));
    cfg_write(CFG_GRID_OFFSET, CFG_DATA_W'(offset));
    cfg_write(CFG_RADIUS_SQ, radius);
    cfg_write(CFG_LATENT_LEN, CFG_DATA_W'(len));
    cfg_write(CFG_BIAS_ENABLE, CFG_DATA_W'(bias));
    cfg_we     <= 1'b0;
    depth_cfg  = depth;
    height_cfg = height;
    offset_cfg = offset;
    radius_cfg = radius;
    len_cfg    = len;
    bias_cfg   = bias;
  endtask

  // Mixed traffic: mostly queries and writes to complete rows, plus noise.
  task automatic run_random_traffic(int count);
    voxel_req_t  q;
    logic [17:0] spot;
    int          done;
    int          pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (voxel_history.size() != 0 && $urandom_range(0, 2) == 0)
          spot = voxel_history[$urandom_range(0, voxel_history.size() - 1)];
        else
          spot = $urandom;
        send_query(spot[17:12], spot[11:6], spot[5:0], random_q16(), random_q16());
      end else if (pick < 60) begin
        q = random_request(REQ_GRID);
        if ($urandom_range(0, 4) != 0) q.row = pick_loaded_row();
        send_request(q);
      end else if (pick < 74) begin
        q = random_request(REQ_WEIGHT);
        if ($urandom_range(0, 3) != 0) q.row = pick_loaded_row();
        send_request(q);
      end else if (pick < 82) begin
        q = random_request(REQ_BIAS);
        if ($urandom_range(0, 3) != 0) q.row = pick_loaded_row();
        send_request(q);
      end else if (pick < 90) begin
        send_request(random_request(REQ_LATENT));
      end else if (pick < 92 && loaded_rows.size() < 24) begin
        load_row($urandom_range(0, WEIGHT_ROWS_DEF - 1));
      end else begin
        // Unused request kinds are dropped by the block and do not count.
        send_request(random_request(3'($urandom_range(int'(REQ_QUERY) + 1, REQ_KIND_LAST))));
        continue;
      end
      done++;
    end
  endtask

  // Latent vector first, then a pool of complete rows including both end rows.
  task automatic test_store_loading();
    voxel_req_t q;
    int         i;
    for (i = 0; i < LATENT_MAX_DEF; i++) begin
      q = random_request(REQ_LATENT);
      q.pos = 4'(i);
      send_request(q);
    end
    load_row('0);
    load_row('1);
    load_row(12'hAAA);
    load_row(12'h555);
    repeat (4) load_row($urandom_range(0, WEIGHT_ROWS_DEF - 1));
  endtask

  task automatic test_directed_cases();
    voxel_req_t q;
    int         k;
    // Center with zero previous values, then origin and far corner with extreme ones.
    send_query(6'd31, 6'd31, 6'd0, '0, '0);
    send_query('0, '0, '0, VALUE_MAX, VALUE_MIN);
    send_query('1, '1, '1, VALUE_MIN, VALUE_MAX);
    // Full-scale weight and latent so both parts saturate, one each way.
    map_voxel(6'd1, 6'd2, 6'd3, '1);
    q = random_request(REQ_WEIGHT);
    q.row  = '1;
    q.pos  = '0;
    q.part = 1'b0;
    q.wval = VALUE_MAX;
    send_request(q);
    q.part = 1'b1;
    q.wval = VALUE_MIN;
    send_request(q);
    q = random_request(REQ_LATENT);
    q.pos  = '0;
    q.wval = VALUE_MAX;
    send_request(q);
    send_query(6'd1, 6'd2, 6'd3, VALUE_MAX, VALUE_MIN);
    send_query(6'd1, 6'd2, 6'd3, VALUE_MIN, VALUE_MAX);
    q.wval = $urandom_range(0, 32'h1FFFF) - 32'h10000;
    send_request(q);
    // Unused request kinds, then a query to show nothing changed.
    for (k = int'(REQ_QUERY) + 1; k <= REQ_KIND_LAST; k++)
      send_request(random_request(3'(k)));
    send_query(6'd31, 6'd31, 6'd0, random_q16(), random_q16());
    // Grid write at the last grid entry.
    q = random_request(REQ_GRID);
    q.z   = '1;
    q.y   = '1;
    q.x   = '1;
    q.row = '1;
    send_request(q);
    send_query('1, '1, '1, random_q16(), random_q16());
  endtask

  task automatic test_config_corners();
    // Zero volume sizes center on 0, widest padding wraps lookups, empty dot product.
    apply_settings(7'd0, 7'd0, 5'd31, 14'h3FFF, 5'd0, 1'b1);
    run_random_traffic(150);
    // Widest sizes, latent length past the store depth, no bias.
    apply_settings(7'h7F, 7'h7F, 5'd17, 14'd4000, 5'h1F, 1'b0);
    run_random_traffic(150);
    // Zero radius limit: every voxel passes its previous values through.
    apply_settings(7'd1, 7'd64, 5'd5, 14'd0, 5'd1, 1'b1);
    run_random_traffic(120);
  endtask

  task automatic test_random_settings();
    int i;
    for (i = 0; i < 4; i++) begin
      // One phase runs without any gaps or stalls.
      tx_gaps_on   <= (i != 2);
      rx_stalls_on <= (i != 2);
      apply_settings($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 31),
                     $urandom_range(0, 12288), $urandom_range(1, 16), $urandom_range(0, 1));
      run_random_traffic(200);
    end
  endtask

  task automatic test_default_run();
    tx_gaps_on   <= 1'b1;
    rx_stalls_on <= 1'b1;
    apply_settings(VOL_DEPTH_RST, VOL_HEIGHT_RST, GRID_OFFSET_RST, RADIUS_SQ_RST,
                   LATENT_LEN_RST, BIAS_ENABLE_RST);
    run_random_traffic(300);
  endtask

  // Result side backpressure.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = rx_stalls_on ? random_gap() : 0;
      m_tready   <= (stall_len == 0);
      stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_xfer_q === 1'b1) begin
      if (voxel_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: re=%0d im=%0d in_sphere=%0b",
                   $signed(out_data_q[31:0]), $signed(out_data_q[63:32]), out_user_q[0]);
      end else begin
        oldest_voxel = voxel_expect_q.pop_front();
        if (out_data_q[31:0] !== oldest_voxel.re || out_data_q[63:32] !== oldest_voxel.im ||
            out_user_q[0] !== oldest_voxel.in_sphere) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected re=%0d im=%0d in_sphere=%0b, got re=%0d im=%0d in_sphere=%0b",
                     $signed(oldest_voxel.re), $signed(oldest_voxel.im), oldest_voxel.in_sphere,
                     $signed(out_data_q[31:0]), $signed(out_data_q[63:32]), out_user_q[0]);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (in_xfer_q === 1'b1 || out_xfer_q === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_store_loading();
    test_directed_cases();
    test_config_corners();
    test_random_settings();
    test_default_run();
    wait_idle();
    if (error_count == 0 && voxel_expect_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
